FILE: src/ssp_pkg.sv
package ssp_pkg;

  // ASCII code of the decimal point; it sets the dot bit instead of taking a digit
  localparam logic [7:0] DotChar = 8'h2E;
  // dot bit inside one segment byte
  localparam logic [7:0] DotSeg = 8'h80;
  // entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // one classified character, as it travels from front to back
  typedef struct packed {
    logic [7:0] pattern;  // segment pattern of a digit character
    logic       is_dot;   // character is the decimal point
    logic       last;     // final character of the string
  } ssp_item_t;

  // 7-segment font, blank for codes without a glyph
  function automatic logic [7:0] font_of(input logic [7:0] c);
    logic [7:0] seg;
    unique case (c)
      8'h2D: seg = 8'h40;                  // '-'
      8'h5F: seg = 8'h08;                  // '_'
      8'h7E: seg = 8'h01;                  // '~'
      8'h41: seg = 8'h77;                  // 'A'
      8'h43: seg = 8'h39;                  // 'C'
      8'h45: seg = 8'h79;                  // 'E'
      8'h46: seg = 8'h71;                  // 'F'
      8'h47: seg = 8'h3D;                  // 'G'
      8'h48: seg = 8'h76;                  // 'H'
      8'h49: seg = 8'h30;                  // 'I'
      8'h4A: seg = 8'h0E;                  // 'J'
      8'h4C: seg = 8'h38;                  // 'L'
      8'h50: seg = 8'h73;                  // 'P'
      8'h55: seg = 8'h3E;                  // 'U'
      8'h59: seg = 8'h72;                  // 'Y'
      8'h62: seg = 8'h7C;                  // 'b'
      8'h63: seg = 8'h58;                  // 'c'
      8'h64: seg = 8'h5E;                  // 'd'
      8'h68: seg = 8'h74;                  // 'h'
      8'h6E: seg = 8'h54;                  // 'n'
      8'h6F: seg = 8'h5C;                  // 'o'
      8'h72: seg = 8'h50;                  // 'r'
      8'h74: seg = 8'h78;                  // 't'
      8'h75: seg = 8'h1C;                  // 'u'
      8'h44, 8'h4F, 8'h30: seg = 8'h3F;    // 'D' 'O' '0'
      8'h31: seg = 8'h06;
      8'h32: seg = 8'h5B;
      8'h33: seg = 8'h4F;
      8'h34: seg = 8'h66;
      8'h35: seg = 8'h6D;
      8'h36: seg = 8'h7D;
      8'h37: seg = 8'h07;
      8'h42, 8'h38: seg = 8'h7F;           // 'B' '8'
      8'h39: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: src/ssp_front.sv
module ssp_front
  import ssp_pkg::*;
(
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // end_of_text
  input  logic       q_full_i,
  output logic       q_push_o,
  output ssp_item_t  q_item_o
);

  // accept whenever the queue has room
  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  // classify: period vs. digit, and font lookup
  assign q_item_o.is_dot  = (s_axis_tdata == DotChar);
  assign q_item_o.pattern = font_of(s_axis_tdata);
  assign q_item_o.last    = s_axis_tlast;

endmodule

FILE: src/ssp_queue.sv
module ssp_queue
  import ssp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  ssp_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output ssp_item_t item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  ssp_item_t       mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue fill count above depth");

endmodule

FILE: src/ssp_back.sv
module ssp_back
  import ssp_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  ssp_item_t   q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_word_o,
  output logic [2:0]  out_digits_o
);

  localparam logic [3:0] LimitC = 4'(DIGIT_COUNT);

  logic [31:0] word_q, word_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        skip_q, skip_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_cnt_q, out_cnt_d;

  logic [31:0] word_next;
  logic [3:0]  cnt_sum;
  logic        full, emit;

  // take the next transaction when the output register is free or draining
  assign q_pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  // packing datapath
  always_comb begin
    if (q_item_i.is_dot) begin
      word_next = word_q | {24'h0, DotSeg};
      cnt_sum   = {1'b0, cnt_q};
    end else begin
      word_next = {word_q[23:0], q_item_i.pattern};
      cnt_sum   = {1'b0, cnt_q} + 4'd1;
    end
    full = ~q_item_i.is_dot & (cnt_sum == LimitC);
    emit = ~skip_q & (full | q_item_i.last);
  end

  // state and output register update
  always_comb begin
    word_d      = word_q;
    cnt_d       = cnt_q;
    skip_d      = skip_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_word_d  = out_word_q;
    out_cnt_d   = out_cnt_q;
    if (q_pop_o) begin
      if (skip_q) begin
        // drop characters until the end of the string
        if (q_item_i.last) begin
          skip_d = 1'b0;
        end
      end else if (emit) begin
        out_valid_d = 1'b1;
        out_word_d  = word_next;
        out_cnt_d   = cnt_sum[2:0];
        word_d      = '0;
        cnt_d       = '0;
        skip_d      = full & ~q_item_i.last;
      end else begin
        word_d = word_next;
        cnt_d  = cnt_sum[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q      <= '0;
      cnt_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      word_q      <= word_d;
      cnt_q       <= cnt_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign out_digits_o = out_cnt_q;

  a_cnt_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < LimitC)
    else $error("digit count reached limit without emitting");

  a_skip_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> (word_q == '0) && (cnt_q == '0))
    else $error("skipping with a partly built word");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && emit |=> out_valid_q)
    else $error("emitted result not presented");

endmodule

FILE: src/seven_segment_string_packer_unit.sv
// Seven-segment string packer.
// Input stream: one ASCII character per transaction on s_axis_tdata, with
// s_axis_tlast on the final character of a string. Output stream: one packed
// word per finished string, or as soon as DIGIT_COUNT digits are packed; the
// rest of such a string is then dropped, trailing periods included.
// A period sets the dot bit of the newest digit and takes no digit position.
// Throughput: one character per cycle unless the output stalls. A front stage decodes
// the font and writes a two-entry queue; the back stage packs one queued character a
// cycle, unless stalled, into the word register and loads the output register.
// A result passes through the queue and the output register on its way to m_axis.
// Stall: while m_axis_tready is low the result holds and the back stage
// stops taking characters; the queue fills its two entries before
// s_axis_tready drops.
// Reset: clears the word, the digit count, the skip flag, the queue and the
// output valid; no transaction is in flight afterwards.
module seven_segment_string_packer_unit
  import ssp_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [31:0] segment_word, [34:32] digits_used
);

  logic        q_full, q_push, q_pop, q_valid;
  ssp_item_t   q_in, q_out;
  logic [31:0] seg_word;
  logic [2:0]  digits;

  ssp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  ssp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  ssp_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_item_i     (q_out),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (seg_word),
    .out_digits_o (digits)
  );

  assign m_axis_tdata = {5'b0, digits, seg_word};

endmodule

FILE: verif/seven_seg_word_checker.sv
module seven_seg_word_checker
  import ssp_pkg::*;
#(
  parameter int unsigned DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,   // [7:0] char_code
  input  logic        s_last_i,   // end_of_text
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,   // [31:0] segment_word, [34:32] digits_used
  output int          fail_count_o,
  output int          words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  digits;
  } seg_word_t;

  seg_word_t   word_exp_q[$];
  logic [31:0] word_acc = '0;
  logic [2:0]  digit_cnt = '0;
  logic        dropping = 1'b0;
  int          fails = 0;

  // segment pattern per character, blank where there is no glyph
  function automatic logic [7:0] glyph_bits(input logic [7:0] ch);
    case (ch)
      "-": return 8'h40;
      "_": return 8'h08;
      "~": return 8'h01;
      "A": return 8'h77;
      "C": return 8'h39;
      "E": return 8'h79;
      "F": return 8'h71;
      "G": return 8'h3D;
      "H": return 8'h76;
      "I": return 8'h30;
      "J": return 8'h0E;
      "L": return 8'h38;
      "P": return 8'h73;
      "U": return 8'h3E;
      "Y": return 8'h72;
      "b": return 8'h7C;
      "c": return 8'h58;
      "d": return 8'h5E;
      "h": return 8'h74;
      "n": return 8'h54;
      "o": return 8'h5C;
      "r": return 8'h50;
      "t": return 8'h78;
      "u": return 8'h1C;
      "D", "O", "0": return 8'h3F;
      "1": return 8'h06;
      "2": return 8'h5B;
      "3": return 8'h4F;
      "4": return 8'h66;
      "5": return 8'h6D;
      "6": return 8'h7D;
      "7": return 8'h07;
      "B", "8": return 8'h7F;
      "9": return 8'h6F;
      default: return 8'h00;
    endcase
  endfunction

  // advance the packing state by one character, queue a word if one is due
  task automatic pack_char(input logic [7:0] ch, input logic lst);
    int unsigned cnt;
    logic        full;
    seg_word_t   w;
    cnt  = 32'(digit_cnt);
    full = 1'b0;
    if (dropping) begin
      if (lst) begin
        word_acc  = '0;
        digit_cnt = '0;
        dropping  = 1'b0;
      end
      return;
    end
    if (ch == DotChar) begin
      word_acc = word_acc | {24'h0, DotSeg};
    end else begin
      word_acc = {word_acc[23:0], glyph_bits(ch)};
      cnt      = cnt + 1;
      full     = (cnt == DIGITS);
    end
    if (full || lst) begin
      w.word   = word_acc;
      w.digits = cnt[2:0];
      word_exp_q.push_back(w);
      word_acc  = '0;
      digit_cnt = '0;
      dropping  = full && !lst;
    end else begin
      digit_cnt = cnt[2:0];
    end
  endtask

  // outputs first, so a word never meets the expectation queued at the same edge
  always @(posedge clk_i) begin
    seg_word_t w;
    if (rst_ni) begin
      if (m_valid_i && m_ready_i) begin
        if (word_exp_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected word %h digits %0d", $realtime,
                     m_data_i[31:0], m_data_i[34:32]);
        end else begin
          w = word_exp_q.pop_front();
          if (m_data_i[31:0] !== w.word || m_data_i[34:32] !== w.digits ||
              m_data_i[39:35] !== 5'b0) begin
            fails++;
            if (fails <= 10)
              $display("%0t: word exp %h got %h, digits exp %0d got %0d, pad %b",
                       $realtime, w.word, m_data_i[31:0], w.digits,
                       m_data_i[34:32], m_data_i[39:35]);
          end
        end
      end
      if (s_valid_i && s_ready_i)
        pack_char(s_data_i, s_last_i);
    end
    fail_count_o    <= fails;
    words_pending_o <= word_exp_q.size();
  end

endmodule

FILE: verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned PhaseItems = 170;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // [31:0] segment_word, [34:32] digits_used

  int          fail_count;
  int          words_pending;
  int unsigned src_idle_pct = 0;
  int unsigned dst_stall_pct = 0;
  int unsigned cycles = 0;
  int unsigned chars_sent = 0;

  string       glyphs = "-_~ACEFGHIJLPUYbcdhnortuDO0123456789B";

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  seven_segment_string_packer_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  seven_seg_word_checker chk (
    .clk_i,
    .rst_ni,
    .s_valid_i       (s_axis_tvalid),
    .s_ready_i       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .s_last_i        (s_axis_tlast),
    .m_valid_i       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_i        (m_axis_tdata),
    .fail_count_o    (fail_count),
    .words_pending_o (words_pending)
  );

  // receiver backpressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one character transaction, with an optional idle gap in front
  task automatic send_char(input logic [7:0] ch, input logic lst);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chars_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++)
      send_char(txt[i], i == txt.len() - 1);
  endtask

  // stop sending until every queued word has come out
  task automatic drain_words();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
  endtask

  // random string: mostly displayable text with dots, some raw bytes
  task automatic send_random_string();
    int unsigned len;
    int unsigned pick;
    logic [7:0]  ch;
    len = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(6, 1);
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 25)
        ch = ssp_pkg::DotChar;
      else if (pick < 70)
        ch = glyphs[$urandom_range(glyphs.len() - 1)];
      else
        ch = 8'($urandom_range(255));
      send_char(ch, i == len - 1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    send_text(".");              // lone dot, no digit yet
    send_text("..A");            // repeated dot before the first digit
    send_char(8'h00, 1'b0);      // unknown codes pack blanks
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
    send_text("ABCD.");          // dot after the fourth digit is dropped
    send_text("8.8.8.8.");       // dots on the first three digits, trailing dot lost
    send_text("1234");           // limit reached on the final character
    send_text("~_5");
    drain_words();

    // random strings under each idling mode
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1: begin src_idle_pct = 68; dst_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  dst_stall_pct = 68; end
        default: begin src_idle_pct = 27; dst_stall_pct = 27; end
      endcase
      chars_sent = 0;
      while (chars_sent < PhaseItems)
        send_random_string();
      drain_words();
    end

    dst_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
